### rtl/bcvs_pkg.sv
// ============================================================================
// bcvs_pkg
// Types and constants shared by the button click value selector modules.
// ============================================================================
`default_nettype none

package bcvs_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 16;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = CFG_W'(200);
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = CFG_W'(300);

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_DEBOUNCE     = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_DOUBLE_CLICK = INDEX_W'(1);

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd2
    } step_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              up_low;
        logic              mode_low;
        logic              enter_low;
    } item_t;

    typedef struct packed {
        logic               side_select;
        logic [VALUE_W-1:0] left_count;
        logic [VALUE_W-1:0] right_count;
        logic [TIME_W-1:0]  up_accept_time;
        logic [TIME_W-1:0]  up_first_press_time;
        logic [TIME_W-1:0]  mode_accept_time;
        logic [TIME_W-1:0]  enter_accept_time;
        logic               click_armed;
        logic               double_seen;
    } state_t;

    typedef struct packed {
        logic                      side;
        logic signed [VALUE_W-1:0] side_value;
        step_t                     value_step;
        logic                      side_toggled;
        logic                      saved;
        logic                      saved_side;
        logic signed [VALUE_W-1:0] saved_value;
    } result_t;

endpackage

`default_nettype wire

### rtl/bcvs_step.sv
// ============================================================================
// bcvs_step
// Combinational handling of one poll: mode toggle, click detector, enter save.
// ============================================================================
`default_nettype none

module bcvs_step (
    input  wire bcvs_pkg::item_t              item,
    input  wire bcvs_pkg::state_t             state,
    input  wire [bcvs_pkg::CFG_W-1:0]         debounce_ms,
    input  wire [bcvs_pkg::CFG_W-1:0]         double_click_ms,
    output bcvs_pkg::state_t                  state_next,
    output bcvs_pkg::result_t                 result
);
    import bcvs_pkg::*;

    logic [TIME_W-1:0]  gap_mode;
    logic [TIME_W-1:0]  gap_up;
    logic [TIME_W-1:0]  gap_first;
    logic [TIME_W-1:0]  debounce_w;
    logic [TIME_W-1:0]  double_w;
    logic               mode_hit;
    logic               up_hit;
    logic               enter_hit;
    logic               in_window;
    logic               do_dec;
    logic               do_inc;
    logic               side_new;
    logic [VALUE_W-1:0] cur_value;
    logic [VALUE_W-1:0] stepped_value;
    logic [VALUE_W-1:0] final_value;

    always_comb begin
        debounce_w = {{(TIME_W-CFG_W){1'b0}}, debounce_ms};
        double_w   = {{(TIME_W-CFG_W){1'b0}}, double_click_ms};

        gap_mode  = item.time_ms - state.mode_accept_time;
        gap_up    = item.time_ms - state.up_accept_time;
        gap_first = item.time_ms - state.up_first_press_time;

        mode_hit  = item.mode_low && (gap_mode > debounce_w);
        up_hit    = item.up_low && (gap_up > debounce_w);
        enter_hit = item.enter_low && ((item.time_ms - state.enter_accept_time) > debounce_w);
        in_window = (gap_first <= double_w);

        // Second press inside the window counts down; a release after the
        // window with no double click counts up.
        do_dec = up_hit && state.click_armed && in_window;
        do_inc = !item.up_low && state.click_armed && !in_window && !state.double_seen;

        side_new  = state.side_select ^ mode_hit;
        cur_value = side_new ? state.right_count : state.left_count;

        if (do_dec) begin
            stepped_value = cur_value - VALUE_W'(1);
        end else if (do_inc) begin
            stepped_value = cur_value + VALUE_W'(1);
        end else begin
            stepped_value = cur_value;
        end
        final_value = enter_hit ? '0 : stepped_value;

        state_next             = state;
        state_next.side_select = side_new;
        if (side_new) begin
            state_next.right_count = final_value;
        end else begin
            state_next.left_count = final_value;
        end
        if (mode_hit) begin
            state_next.mode_accept_time = item.time_ms;
        end
        if (up_hit) begin
            state_next.up_accept_time = item.time_ms;
            if (!state.click_armed) begin
                state_next.up_first_press_time = item.time_ms;
            end
        end
        if (enter_hit) begin
            state_next.enter_accept_time = item.time_ms;
        end
        if (item.up_low) begin
            if (up_hit && !state.click_armed) begin
                state_next.click_armed = 1'b1;
            end else if (do_dec) begin
                state_next.click_armed = 1'b0;
            end
            state_next.double_seen = state.double_seen | do_dec;
        end else begin
            if (do_inc) begin
                state_next.click_armed = 1'b0;
            end
            state_next.double_seen = 1'b0;
        end

        result.side         = side_new;
        result.side_value   = final_value;
        result.value_step   = do_dec ? STEP_DEC : (do_inc ? STEP_INC : STEP_NONE);
        result.side_toggled = mode_hit;
        result.saved        = enter_hit;
        result.saved_side   = enter_hit & side_new;
        result.saved_value  = enter_hit ? stepped_value : '0;
    end

endmodule

`default_nettype wire

### rtl/button_click_value_selector.sv
// ============================================================================
// button_click_value_selector
// Debounced mode/up/enter button handling with single and double click
// detection on the up button, one result item per poll item.
// ============================================================================
// Each input item is one poll: a free-running millisecond timestamp and the
// three active-low button levels. The poll is captured in an input register,
// handled in a single pass of short logic (mode toggles the side, up runs the
// click detector on the current side's value, enter saves and clears it) and
// the result item is written to an output register. One item is accepted per
// clock cycle unless both registers are full and the output is stalled. The
// step logic makes one state update per poll, and the output register lets a
// new poll enter while a finished result still waits to be taken. The two
// configuration registers (debounce gap and double-click window) should be
// written only while no poll is in flight.
`default_nettype none

module button_click_value_selector (
    input  wire                            aclk,
    input  wire                            aresetn,
    // Poll items. s_tdata fields from bit 0: time_ms[31:0], up_low, mode_low,
    // enter_low, then zero fill to 40 bits.
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [39:0]                     s_tdata,
    // Result items. m_tdata fields from bit 0: side, side_value[15:0],
    // value_step[1:0], side_toggled, saved, saved_side, saved_value[15:0],
    // then zero fill to 40 bits.
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [39:0]                    m_tdata,
    // Configuration writes: index 0 debounce_ms, index 1 double_click_ms.
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [bcvs_pkg::INDEX_W-1:0]    cfg_index,
    input  wire [bcvs_pkg::CFG_W-1:0]      cfg_data
);
    import bcvs_pkg::*;

    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_result_reg;
    state_t           state_reg;
    state_t           state_next;
    result_t          result_next;
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] double_click_reg;
    logic             out_free;
    logic             advance;

    // The output register is free when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00,
                        out_result_reg.saved_value,
                        out_result_reg.saved_side,
                        out_result_reg.saved,
                        out_result_reg.side_toggled,
                        out_result_reg.value_step,
                        out_result_reg.side_value,
                        out_result_reg.side};

    bcvs_step u_step (
        .item            (in_item_reg),
        .state           (state_reg),
        .debounce_ms     (debounce_reg),
        .double_click_ms (double_click_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RESET;
            double_click_reg <= DOUBLE_CLICK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:     debounce_reg     <= cfg_data;
                REG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: takes a new poll whenever it is empty or moving on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.time_ms   <= s_tdata[31:0];
            in_item_reg.up_low    <= s_tdata[32];
            in_item_reg.mode_low  <= s_tdata[33];
            in_item_reg.enter_low <= s_tdata[34];
        end
    end

    // Block state moves on exactly when a poll passes into the output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    // A saved side is always cleared, so its value reads zero afterwards.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result_reg.saved) |-> (out_result_reg.side_value == '0)
                                            && (out_result_reg.saved_side == out_result_reg.side))
        else $error("saved side not cleared");

    // Without a save the saved fields are zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_result_reg.saved) |-> (out_result_reg.saved_value == '0)
                                             && !out_result_reg.saved_side)
        else $error("saved fields set without a save");

    // Back-pressure on the input only when both stages are full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && in_valid_reg))
        else $error("input stalled without output back-pressure");

    // A stalled result with a waiting poll must not change the block state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(state_reg))
        else $error("state changed while output stalled");

endmodule

`default_nettype wire

### dv/button_click_value_selector_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// button_click_value_selector_tb
// Self-checking bench for the debounced button click value selector.
// ============================================================================
// Poll items go in through the s_ stream and result items are taken from the
// m_ stream. Each accepted poll goes through a predictor of the selector in
// the bench, and the result it gives is queued. Each result item must match
// the oldest queued prediction field by field. The run starts with a short
// directed sequence: debounce and window boundaries, a double click, single
// clicks, a save, a timestamp wrap and time running backwards. Random button
// traffic follows under several debounce and window settings and idling
// patterns. A short counting run then raises a side's value by a series of
// single clicks and saves it.
// ============================================================================

module button_click_value_selector_tb;

    import bcvs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_POLLS = 200;
    localparam int unsigned COUNT_CLICKS = 100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // time_ms[31:0], up_low, mode_low, enter_low, zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // side, side_value[15:0], value_step[1:0],
                                   // side_toggled, saved, saved_side,
                                   // saved_value[15:0], zero fill
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    button_click_value_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Polls waiting to be sent, and the results predicted for accepted polls.
    item_t   polls_to_send[$];
    result_t expected_results[$];
    item_t   poll_on_bus;

    int unsigned polls_queued = 0;
    int unsigned polls_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Idling percentages for the current phase.
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;

    // Timestamp that the stimulus has reached.
    logic [TIME_W-1:0] stim_ms = '0;

    // The bench's own copy of the timing registers and the selector state.
    logic [CFG_W-1:0]   debounce_gap = DEBOUNCE_RESET;
    logic [CFG_W-1:0]   dclick_window = DOUBLE_CLICK_RESET;
    logic               side_now = 1'b0;
    logic [VALUE_W-1:0] count_left = '0;
    logic [VALUE_W-1:0] count_right = '0;
    logic [TIME_W-1:0]  up_press_t = '0;
    logic [TIME_W-1:0]  first_click_t = '0;
    logic [TIME_W-1:0]  mode_press_t = '0;
    logic [TIME_W-1:0]  enter_press_t = '0;
    logic               click_pending = 1'b0;
    logic               double_clicked = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: one poll in, one result out, state updated in the same order
    // as the block handles the buttons (mode, then up, then enter). All gaps
    // are 32-bit differences, so a timestamp that went backwards reads as a
    // very long gap.
    // ------------------------------------------------------------------------
    function automatic result_t next_selector_result(input item_t poll);
        result_t r;
        r = '0;
        if (poll.mode_low && (poll.time_ms - mode_press_t) > TIME_W'(debounce_gap)) begin
            side_now = ~side_now;
            mode_press_t = poll.time_ms;
            r.side_toggled = 1'b1;
        end
        if (poll.up_low) begin
            if ((poll.time_ms - up_press_t) > TIME_W'(debounce_gap)) begin
                if (!click_pending) begin
                    click_pending = 1'b1;
                    first_click_t = poll.time_ms;
                end else if ((poll.time_ms - first_click_t) <= TIME_W'(dclick_window)) begin
                    // Second press inside the window: a double click lowers the value.
                    double_clicked = 1'b1;
                    if (side_now)
                        count_right = count_right - 1'b1;
                    else
                        count_left = count_left - 1'b1;
                    click_pending = 1'b0;
                    r.value_step = STEP_DEC;
                end
                up_press_t = poll.time_ms;
            end
        end else begin
            // Released with the window run out and no double click: single click.
            if (click_pending && (poll.time_ms - first_click_t) > TIME_W'(dclick_window)
                    && !double_clicked) begin
                if (side_now)
                    count_right = count_right + 1'b1;
                else
                    count_left = count_left + 1'b1;
                click_pending = 1'b0;
                r.value_step = STEP_INC;
            end
            double_clicked = 1'b0;
        end
        if (poll.enter_low && (poll.time_ms - enter_press_t) > TIME_W'(debounce_gap)) begin
            r.saved = 1'b1;
            r.saved_side = side_now;
            r.saved_value = side_now ? count_right : count_left;
            if (side_now)
                count_right = '0;
            else
                count_left = '0;
            enter_press_t = poll.time_ms;
        end
        r.side = side_now;
        r.side_value = side_now ? count_right : count_left;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued polls on the s_ stream. A held item is never
    // withdrawn; a gap is only inserted when the bus is free to change.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(next_selector_result(poll_on_bus));
                polls_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (polls_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    poll_on_bus = polls_to_send.pop_front();
                    s_tdata <= {5'b0, poll_on_bus.enter_low, poll_on_bus.mode_low,
                                poll_on_bus.up_low, poll_on_bus.time_ms};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR result %0d, %s: got %0d, expected %0d",
                 results_checked, field, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: takes result items from the m_ stream and checks each against
    // the oldest prediction. m_tready is randomised as the phase asks.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_t got, want;
                got.side = m_tdata[0];
                got.side_value = m_tdata[16:1];
                got.value_step = step_t'(m_tdata[18:17]);
                got.side_toggled = m_tdata[19];
                got.saved = m_tdata[20];
                got.saved_side = m_tdata[21];
                got.saved_value = m_tdata[37:22];
                results_checked++;
                if (expected_results.size() == 0) begin
                    $display("ERROR result %0d arrived with no poll to account for it",
                             results_checked);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.side !== want.side)
                        report_mismatch("side", got.side, want.side);
                    if (got.side_value !== want.side_value)
                        report_mismatch("side_value", $signed(got.side_value),
                                        $signed(want.side_value));
                    if (got.value_step !== want.value_step)
                        report_mismatch("value_step", got.value_step, want.value_step);
                    if (got.side_toggled !== want.side_toggled)
                        report_mismatch("side_toggled", got.side_toggled, want.side_toggled);
                    if (got.saved !== want.saved)
                        report_mismatch("saved", got.saved, want.saved);
                    if (got.saved_side !== want.saved_side)
                        report_mismatch("saved_side", got.saved_side, want.saved_side);
                    if (got.saved_value !== want.saved_value)
                        report_mismatch("saved_value", $signed(got.saved_value),
                                        $signed(want.saved_value));
                    if (m_tdata[39:38] !== 2'b00)
                        report_mismatch("zero fill", m_tdata[39:38], 0);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a run that hangs is a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("button_click_value_selector_tb: done, errors");
        $finish;
    end

    function automatic void queue_poll(input logic [TIME_W-1:0] t, input logic up,
                                       input logic mode, input logic enter);
        item_t p;
        p.time_ms = t;
        p.up_low = up;
        p.mode_low = mode;
        p.enter_low = enter;
        polls_to_send.push_back(p);
        polls_queued++;
        stim_ms = t;
    endfunction

    // Time between polls, scaled to the current settings so that gaps fall
    // on both sides of the debounce and double-click limits. A few jumps are
    // fully random, which also wraps the timestamp or sends it backwards.
    function automatic logic [TIME_W-1:0] next_poll_gap();
        int unsigned span, pick, edge_ms;
        span = ((debounce_gap > dclick_window) ? debounce_gap : dclick_window) + 1;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(span / 3 + 1);
        if (pick < 85) begin
            edge_ms = $urandom_range(1) ? debounce_gap : dclick_window;
            return edge_ms + $urandom_range(2);
        end
        if (pick < 96)
            return $urandom_range(2 * span);
        return $urandom();
    endfunction

    // Random button traffic: each button holds a level for a few polls, as a
    // real press would, with some polls carrying random levels as noise.
    task automatic queue_random_polls(input int unsigned count);
        logic [2:0]  level;
        int unsigned hold [3];
        logic [2:0]  pins;
        level = '0;
        foreach (hold[b])
            hold[b] = $urandom_range(1, 6);
        repeat (count) begin
            foreach (hold[b]) begin
                if (hold[b] == 0) begin
                    level[b] = ~level[b];
                    hold[b] = $urandom_range(1, 6);
                end
                hold[b]--;
            end
            pins = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : level;
            queue_poll(stim_ms + next_poll_gap(), pins[0], pins[1], pins[2]);
        end
    endtask

    // Waits until every queued poll has been accepted and every result has
    // been checked.
    task automatic wait_drained();
        while (polls_accepted != polls_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both timing registers back to back; called only while idle.
    task automatic program_timing(input logic [CFG_W-1:0] debounce,
                                  input logic [CFG_W-1:0] window);
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= debounce;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        debounce_gap = debounce;
        cfg_index <= REG_DOUBLE_CLICK;
        cfg_data <= window;
        do @(posedge aclk); while (!cfg_ready);
        dclick_window = window;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(input int unsigned phase);
        case (phase % 4)
            0: begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_gap_pct = 66;
                stall_pct = 0;
            end
            2: begin
                send_gap_pct = 0;
                stall_pct = 66;
            end
            default: begin
                send_gap_pct = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] deb_set [8];
        logic [CFG_W-1:0] win_set [8];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed polls under the reset settings (200 ms debounce, 300 ms
        // window), starting from the cleared state.
        set_idling(3);
        queue_poll(32'd0,    1'b0, 1'b0, 1'b0);  // nothing pressed
        queue_poll(32'd200,  1'b0, 1'b1, 1'b0);  // mode gap equal to debounce: ignored
        queue_poll(32'd201,  1'b0, 1'b1, 1'b0);  // one past: side toggles to right
        queue_poll(32'd250,  1'b1, 1'b0, 1'b0);  // up press arms a click
        queue_poll(32'd300,  1'b0, 1'b0, 1'b0);  // release inside the window
        queue_poll(32'd451,  1'b1, 1'b0, 1'b0);  // second press in window: decrement, wraps
        queue_poll(32'd460,  1'b0, 1'b0, 1'b0);  // release after double click: no increment
        queue_poll(32'd700,  1'b1, 1'b0, 1'b0);  // arm again
        queue_poll(32'd1000, 1'b0, 1'b0, 1'b0);  // window exactly reached: still waiting
        queue_poll(32'd1001, 1'b0, 1'b0, 1'b0);  // window passed: single click increments
        queue_poll(32'd1400, 1'b1, 1'b0, 1'b0);  // arm
        queue_poll(32'd1500, 1'b1, 1'b0, 1'b0);  // held within debounce: not a new press
        queue_poll(32'd1800, 1'b0, 1'b0, 1'b0);  // single click
        queue_poll(32'd1900, 1'b0, 1'b0, 1'b1);  // enter saves the right side and clears it
        queue_poll(32'd2000, 1'b1, 1'b0, 1'b0);  // arm
        queue_poll(32'd2400, 1'b1, 1'b0, 1'b0);  // accepted press after the window: no change
        queue_poll(32'd2401, 1'b0, 1'b0, 1'b0);  // release: single click
        queue_poll(32'd3000, 1'b1, 1'b1, 1'b1);  // all three at once
        queue_poll(32'd3100, 1'b0, 1'b0, 1'b0);
        queue_poll(32'hFFFF_FF00, 1'b0, 1'b1, 1'b0);  // mode just before the wrap
        queue_poll(32'h0000_0010, 1'b0, 1'b1, 1'b0);  // gap across the wrap exceeds debounce
        queue_poll(32'h0000_0005, 1'b0, 1'b0, 1'b1);  // time went backwards: huge gap
        queue_poll(32'h0000_0005, 1'b0, 1'b0, 1'b1);  // same timestamp: zero gap
        queue_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);  // largest timestamp
        wait_drained();

        // Random traffic under a spread of settings, the extremes among them.
        deb_set = '{16'd200, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF,
                    CFG_W'($urandom()), 16'd5, CFG_W'($urandom_range(50))};
        win_set = '{16'd300, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                    CFG_W'($urandom()), 16'd9, CFG_W'($urandom_range(400))};
        for (int unsigned phase = 0; phase < 8; phase++) begin
            program_timing(deb_set[phase], win_set[phase]);
            set_idling(phase);
            stim_ms = $urandom();
            queue_random_polls(RANDOM_POLLS);
            wait_drained();
        end

        // Counting run: with zero debounce and a zero window every press and
        // release pair is a single click, so the value climbs steadily and is
        // then saved.
        program_timing(16'd0, 16'd0);
        set_idling(0);
        stim_ms = stim_ms + 32'd1000;
        queue_poll(stim_ms + 1, 1'b0, 1'b0, 1'b0);   // settles any armed click
        queue_poll(stim_ms + 1, 1'b0, 1'b0, 1'b1);   // clears the current side
        for (int unsigned n = 0; n < COUNT_CLICKS; n++) begin
            queue_poll(stim_ms + 1, 1'b1, 1'b0, 1'b0);
            queue_poll(stim_ms + 1, 1'b0, 1'b0, 1'b0);
        end
        queue_poll(stim_ms + 1, 1'b0, 1'b0, 1'b1);   // saves the counted value
        wait_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("button_click_value_selector_tb: done, clean");
        else
            $display("button_click_value_selector_tb: done, errors");
        $finish;
    end

endmodule
